FILE: hw/rtl/psd_pkg.sv
package psd_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int KIND_W = 3;
    localparam int SIZE_W = WORD_W - 1;

    localparam int DIFF_W = WORD_W + 1;
    localparam int MAG_W  = WORD_W + 2;
    localparam int RAD_W  = 2 * MAG_W;
    localparam int ROOT_W = RAD_W / 2;
    localparam int QUO_W  = WORD_W + FRAC_W + 1;
    localparam int REM_W  = WORD_W;
    localparam int EDGE_W = WORD_W + 3;
    localparam int DIST_W = WORD_W + 5;

    localparam int LATENCY = 2 * ROOT_W + QUO_W + 8;

    localparam logic [MAG_W-1:0] RATIO_CAP =
        {{(MAG_W - WORD_W - 1){1'b0}}, 1'b1, {WORD_W{1'b0}}};
    localparam logic signed [DIST_W-1:0] DIST_ONE =
        {{(DIST_W - FRAC_W - 1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};
    localparam logic signed [DIST_W-1:0] DIST_MAX =
        {{(DIST_W - WORD_W + 1){1'b0}}, {(WORD_W - 1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN =
        {{(DIST_W - WORD_W + 1){1'b1}}, {(WORD_W - 1){1'b0}}};
    localparam logic [SIZE_W-1:0] SIZE_ONE =
        {{(SIZE_W - FRAC_W - 1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

    localparam logic [KIND_W-1:0] SHAPE_SPHERE   = 3'd0;
    localparam logic [KIND_W-1:0] SHAPE_TORUS    = 3'd1;
    localparam logic [KIND_W-1:0] SHAPE_CYLINDER = 3'd2;
    localparam logic [KIND_W-1:0] SHAPE_BOX      = 3'd3;

    localparam logic [2:0] REG_SHAPE_KIND = 3'd0;
    localparam logic [2:0] REG_CENTRE_X   = 3'd1;
    localparam logic [2:0] REG_CENTRE_Y   = 3'd2;
    localparam logic [2:0] REG_CENTRE_Z   = 3'd3;
    localparam logic [2:0] REG_SIZE_A     = 3'd4;
    localparam logic [2:0] REG_SIZE_B     = 3'd5;
    localparam logic [2:0] REG_SIZE_C     = 3'd6;

    typedef struct packed {
        logic signed [WORD_W-1:0] point_x;
        logic signed [WORD_W-1:0] point_y;
        logic signed [WORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] distance;
        logic                     saturated;
    } result_t;

endpackage

FILE: hw/rtl/psd_sqrt.sv
module psd_sqrt
    import psd_pkg::*;
#(
    parameter int TAG_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  in_rad,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [TAG_W-1:0]  out_tag
);

    logic              valid_reg [ROOT_W];
    logic [RAD_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [TAG_W-1:0]  tag_reg   [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - j;
        logic              v_in;
        logic [RAD_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [TAG_W-1:0]  tag_in;
        logic [RAD_W:0]    trial;
        logic              fits;
        logic [RAD_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (j == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_rad;
            assign root_in = '0;
            assign tag_in  = in_tag;
        end
        else begin : g_chain
            assign v_in    = valid_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign tag_in  = tag_reg[j-1];
        end

        // trial = (2*root + 2^bit) * 2^bit
        assign trial = ((RAD_W + 1)'(root_in) << (BIT + 1))
                     | ((RAD_W + 1)'(1) << (2 * BIT));
        assign fits      = {1'b0, rem_in} >= trial;
        assign rem_next  = fits ? rem_in - trial[RAD_W-1:0] : rem_in;
        assign root_next = root_in | (ROOT_W'(fits) << BIT);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= rem_next;
            root_reg[j] <= root_next;
            tag_reg[j]  <= tag_in;
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];

endmodule

FILE: hw/rtl/primitive_signed_distance.sv
// signed distance from a 3-d point to one configured primitive
// (sphere, torus, cylinder, box, ellipsoid), signed q16.16 fixed point
// input: pulse start with a point on point; busy stays low, so a new
//   point may be given in every cycle
// output: done is high for one cycle with result (distance, saturated);
//   the receiver takes every result in that cycle and cannot hold it off
// path: the 49-step ratio divider and the two 34-step root units lie
//   between the start cycle and the done cycle
// throughput: one point per cycle, sustained
// configuration: apb-style port, register i at byte address 4*i;
//   write only while no point is in flight
// reset: rst_n clears the pipeline valid bits and loads the register
//   defaults (sphere, centre at zero, all sizes 1.0); points in flight
//   are dropped
module primitive_signed_distance
    import psd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  point_t            point,
    output logic              done,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef struct packed {
        logic [2:0][DIFF_W-1:0] mag;
        logic [DIFF_W-1:0]      dz;
        logic [2:0][EDGE_W-1:0] box_e;
    } div_carry_t;

    typedef struct packed {
        logic [DIFF_W-1:0]      dz;
        logic [2:0][EDGE_W-1:0] box_e;
    } tag1_t;

    typedef struct packed {
        logic [ROOT_W-1:0]      s1;
        logic [EDGE_W-1:0]      face;
        logic [EDGE_W-1:0]      side;
        logic [2:0][EDGE_W-1:0] box_e;
    } tag2_t;

    localparam int TAG1_W = $bits(tag1_t);
    localparam int TAG2_W = $bits(tag2_t);

    // configuration registers
    logic [KIND_W-1:0]        shape_kind_reg;
    logic signed [WORD_W-1:0] centre_x_reg;
    logic signed [WORD_W-1:0] centre_y_reg;
    logic signed [WORD_W-1:0] centre_z_reg;
    logic [SIZE_W-1:0]        size_a_reg;
    logic [SIZE_W-1:0]        size_b_reg;
    logic [SIZE_W-1:0]        size_c_reg;
    logic                     cfg_wr;
    logic [2:0]               cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_kind_reg <= SHAPE_SPHERE;
            centre_x_reg   <= '0;
            centre_y_reg   <= '0;
            centre_z_reg   <= '0;
            size_a_reg     <= SIZE_ONE;
            size_b_reg     <= SIZE_ONE;
            size_c_reg     <= SIZE_ONE;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SHAPE_KIND: shape_kind_reg <= pwdata[KIND_W-1:0];
                REG_CENTRE_X:   centre_x_reg   <= pwdata[WORD_W-1:0];
                REG_CENTRE_Y:   centre_y_reg   <= pwdata[WORD_W-1:0];
                REG_CENTRE_Z:   centre_z_reg   <= pwdata[WORD_W-1:0];
                REG_SIZE_A:     size_a_reg     <= pwdata[SIZE_W-1:0];
                REG_SIZE_B:     size_b_reg     <= pwdata[SIZE_W-1:0];
                REG_SIZE_C:     size_c_reg     <= pwdata[SIZE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SHAPE_KIND: prdata = {{(DATA_W - KIND_W){1'b0}}, shape_kind_reg};
            REG_CENTRE_X:   prdata = centre_x_reg;
            REG_CENTRE_Y:   prdata = centre_y_reg;
            REG_CENTRE_Z:   prdata = centre_z_reg;
            REG_SIZE_A:     prdata = {{(DATA_W - SIZE_W){1'b0}}, size_a_reg};
            REG_SIZE_B:     prdata = {{(DATA_W - SIZE_W){1'b0}}, size_b_reg};
            REG_SIZE_C:     prdata = {{(DATA_W - SIZE_W){1'b0}}, size_c_reg};
            default:        prdata = '0;
        endcase
    end

    logic [2:0][SIZE_W-1:0] den;
    assign den = {size_c_reg, size_b_reg, size_a_reg};

    // offset from the centre
    logic                     st0_valid_reg;
    logic [2:0][DIFF_W-1:0]   st0_d_reg;
    logic [2:0][DIFF_W-1:0]   st0_d_next;

    assign st0_d_next[0] = {point.point_x[WORD_W-1], point.point_x}
                         - {centre_x_reg[WORD_W-1], centre_x_reg};
    assign st0_d_next[1] = {point.point_y[WORD_W-1], point.point_y}
                         - {centre_y_reg[WORD_W-1], centre_y_reg};
    assign st0_d_next[2] = {point.point_z[WORD_W-1], point.point_z}
                         - {centre_z_reg[WORD_W-1], centre_z_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st0_valid_reg <= 1'b0;
        end
        else
        begin
            st0_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        st0_d_reg <= st0_d_next;
    end

    // magnitudes and box face distances
    div_carry_t st0_carry;

    always_comb
    begin
        st0_carry.dz = st0_d_reg[2];
        for (int g = 0; g < 3; g++)
        begin
            st0_carry.mag[g] = st0_d_reg[g][DIFF_W-1] ? ~st0_d_reg[g] + DIFF_W'(1)
                                                       : st0_d_reg[g];
            st0_carry.box_e[g] = EDGE_W'(($signed({1'b0, st0_carry.mag[g], 1'b0})
                               - $signed({4'b0, den[g]})) >>> 1);
        end
    end

    // ratio divider, one quotient bit per stage
    logic                   dv_valid_reg [QUO_W];
    div_carry_t             dv_carry_reg [QUO_W];
    logic [REM_W-1:0]       dv_rem_reg   [QUO_W][3];
    logic [QUO_W-1:0]       dv_quo_reg   [QUO_W][3];

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        localparam int IT = QUO_W - 1 - k;
        logic       valid_in;
        div_carry_t carry_in;

        if (k == 0) begin : g_first
            assign valid_in = st0_valid_reg;
            assign carry_in = st0_carry;
        end
        else begin : g_chain
            assign valid_in = dv_valid_reg[k-1];
            assign carry_in = dv_carry_reg[k-1];
        end

        for (genvar g = 0; g < 3; g++) begin : g_axis
            logic [REM_W-1:0] rem_in;
            logic [QUO_W-1:0] quo_in;
            logic             dbit;
            logic [REM_W-1:0] rem_cat;
            logic             ge;
            logic [REM_W-1:0] rem_next;
            logic [QUO_W-1:0] quo_next;

            if (k == 0) begin : g_first
                assign rem_in = '0;
                assign quo_in = '0;
            end
            else begin : g_chain
                assign rem_in = dv_rem_reg[k-1][g];
                assign quo_in = dv_quo_reg[k-1][g];
            end

            if (IT >= FRAC_W) begin : g_bit
                assign dbit = carry_in.mag[g][IT-FRAC_W];
            end
            else begin : g_zero
                assign dbit = 1'b0;
            end

            assign rem_cat  = {rem_in[REM_W-2:0], dbit};
            assign ge       = rem_cat >= {1'b0, den[g]};
            assign rem_next = ge ? rem_cat - {1'b0, den[g]} : rem_cat;
            assign quo_next = {quo_in[QUO_W-2:0], ge};

            always_ff @(posedge clk)
            begin
                dv_rem_reg[k][g] <= rem_next;
                dv_quo_reg[k][g] <= quo_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_carry_reg[k] <= carry_in;
        end
    end

    // first vector: offsets or axis ratios
    div_carry_t             dv_last;
    logic                   v1_valid_reg;
    logic [2:0][MAG_W-1:0]  v1_vec_reg;
    logic [2:0][MAG_W-1:0]  v1_vec_next;
    tag1_t                  v1_tag_reg;
    logic [2:0][MAG_W-1:0]  ratio;

    assign dv_last = dv_carry_reg[QUO_W-1];

    always_comb
    begin
        for (int g = 0; g < 3; g++)
        begin
            if (dv_last.mag[g] == '0)
            begin
                ratio[g] = '0;
            end
            else if (|dv_quo_reg[QUO_W-1][g][QUO_W-1:WORD_W])
            begin
                ratio[g] = RATIO_CAP;
            end
            else
            begin
                ratio[g] = MAG_W'(dv_quo_reg[QUO_W-1][g][WORD_W-1:0]);
            end
        end
        case (shape_kind_reg) inside
            SHAPE_SPHERE, SHAPE_BOX:
            begin
                for (int g = 0; g < 3; g++)
                begin
                    v1_vec_next[g] = MAG_W'(dv_last.mag[g]);
                end
            end
            SHAPE_TORUS, SHAPE_CYLINDER:
            begin
                v1_vec_next[0] = MAG_W'(dv_last.mag[0]);
                v1_vec_next[1] = MAG_W'(dv_last.mag[1]);
                v1_vec_next[2] = '0;
            end
            default:
            begin
                v1_vec_next = ratio;
            end
        endcase
    end

    // squares and sum for the first root
    logic                   sq1_valid_reg;
    logic [2:0][RAD_W-1:0]  sq1_reg;
    tag1_t                  sq1_tag_reg;
    logic                   rad1_valid_reg;
    logic [RAD_W-1:0]       rad1_reg;
    tag1_t                  rad1_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_valid_reg   <= 1'b0;
            sq1_valid_reg  <= 1'b0;
            rad1_valid_reg <= 1'b0;
        end
        else
        begin
            v1_valid_reg   <= dv_valid_reg[QUO_W-1];
            sq1_valid_reg  <= v1_valid_reg;
            rad1_valid_reg <= sq1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        v1_vec_reg       <= v1_vec_next;
        v1_tag_reg.dz    <= dv_last.dz;
        v1_tag_reg.box_e <= dv_last.box_e;
        for (int g = 0; g < 3; g++)
        begin
            sq1_reg[g] <= v1_vec_reg[g] * v1_vec_reg[g];
        end
        sq1_tag_reg  <= v1_tag_reg;
        rad1_reg     <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
        rad1_tag_reg <= sq1_tag_reg;
    end

    logic              r1_valid;
    logic [ROOT_W-1:0] r1_root;
    logic [TAG1_W-1:0] r1_tag_bits;
    tag1_t             r1_tag;

    psd_sqrt #(
        .TAG_W (TAG1_W)
    ) u_sqrt1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rad1_valid_reg),
        .in_rad    (rad1_reg),
        .in_tag    (rad1_tag_reg),
        .out_valid (r1_valid),
        .out_root  (r1_root),
        .out_tag   (r1_tag_bits)
    );

    assign r1_tag = r1_tag_bits;

    // second vector: torus ring offset or cylinder face and side
    logic signed [EDGE_W-1:0] tq;
    logic signed [EDGE_W-1:0] tz2a;
    logic [EDGE_W-1:0]        tz2a_mag;
    logic [EDGE_W-1:0]        tq_mag;
    logic [DIFF_W-1:0]        dz_mag;
    logic signed [EDGE_W-1:0] face;
    logic signed [EDGE_W-1:0] side;
    logic                     v2_valid_reg;
    logic [1:0][MAG_W-1:0]    v2_vec_reg;
    logic [1:0][MAG_W-1:0]    v2_vec_next;
    tag2_t                    v2_tag_reg;
    tag2_t                    v2_tag_next;

    always_comb
    begin
        tq       = $signed({1'b0, r1_root}) - $signed({4'b0, size_a_reg});
        tz2a     = $signed({r1_tag.dz[DIFF_W-1], r1_tag.dz, 1'b0})
                 + $signed({4'b0, size_a_reg});
        tz2a_mag = tz2a[EDGE_W-1] ? ~tz2a + EDGE_W'(1) : tz2a;
        face     = ($signed(tz2a_mag) - $signed({4'b0, size_a_reg})) >>> 1;
        side     = $signed({1'b0, r1_root}) - $signed({4'b0, size_b_reg});
        tq_mag   = tq[EDGE_W-1] ? ~tq + EDGE_W'(1) : tq;
        dz_mag   = r1_tag.dz[DIFF_W-1] ? ~r1_tag.dz + DIFF_W'(1) : r1_tag.dz;
        if (shape_kind_reg == SHAPE_CYLINDER)
        begin
            v2_vec_next[0] = MAG_W'(face);
            v2_vec_next[1] = MAG_W'(side);
        end
        else
        begin
            v2_vec_next[0] = MAG_W'(tq_mag);
            v2_vec_next[1] = MAG_W'(dz_mag);
        end
        v2_tag_next.s1    = r1_root;
        v2_tag_next.face  = face;
        v2_tag_next.side  = side;
        v2_tag_next.box_e = r1_tag.box_e;
    end

    logic                   sq2_valid_reg;
    logic [1:0][RAD_W-1:0]  sq2_reg;
    tag2_t                  sq2_tag_reg;
    logic                   rad2_valid_reg;
    logic [RAD_W-1:0]       rad2_reg;
    tag2_t                  rad2_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_valid_reg   <= 1'b0;
            sq2_valid_reg  <= 1'b0;
            rad2_valid_reg <= 1'b0;
        end
        else
        begin
            v2_valid_reg   <= r1_valid;
            sq2_valid_reg  <= v2_valid_reg;
            rad2_valid_reg <= sq2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        v2_vec_reg   <= v2_vec_next;
        v2_tag_reg   <= v2_tag_next;
        sq2_reg[0]   <= v2_vec_reg[0] * v2_vec_reg[0];
        sq2_reg[1]   <= v2_vec_reg[1] * v2_vec_reg[1];
        sq2_tag_reg  <= v2_tag_reg;
        rad2_reg     <= sq2_reg[0] + sq2_reg[1];
        rad2_tag_reg <= sq2_tag_reg;
    end

    logic              r2_valid;
    logic [ROOT_W-1:0] r2_root;
    logic [TAG2_W-1:0] r2_tag_bits;
    tag2_t             r2_tag;

    psd_sqrt #(
        .TAG_W (TAG2_W)
    ) u_sqrt2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rad2_valid_reg),
        .in_rad    (rad2_reg),
        .in_tag    (rad2_tag_reg),
        .out_valid (r2_valid),
        .out_root  (r2_root),
        .out_tag   (r2_tag_bits)
    );

    assign r2_tag = r2_tag_bits;

    // shape select and saturation
    logic signed [EDGE_W-1:0] be0;
    logic signed [EDGE_W-1:0] be1;
    logic signed [EDGE_W-1:0] be2;
    logic signed [EDGE_W-1:0] bmax;
    logic signed [EDGE_W-1:0] fface;
    logic signed [EDGE_W-1:0] fside;
    logic signed [EDGE_W-1:0] cmax;
    logic signed [DIST_W-1:0] dist_raw;
    logic                     axis_zero;
    logic                     done_reg;
    result_t                  result_reg;
    result_t                  result_next;

    always_comb
    begin
        be0   = r2_tag.box_e[0];
        be1   = r2_tag.box_e[1];
        be2   = r2_tag.box_e[2];
        bmax  = (be0 > be1) ? be0 : be1;
        bmax  = (be2 > bmax) ? be2 : bmax;
        fface = r2_tag.face;
        fside = r2_tag.side;
        cmax  = (fface > fside) ? fface : fside;
        case (shape_kind_reg)
            SHAPE_SPHERE:
                dist_raw = $signed(DIST_W'(r2_tag.s1)) - $signed(DIST_W'(size_a_reg));
            SHAPE_TORUS:
                dist_raw = $signed(DIST_W'(r2_root)) - $signed(DIST_W'(size_b_reg));
            SHAPE_CYLINDER:
            begin
                if (fface <= 0 || fside <= 0)
                begin
                    dist_raw = DIST_W'(cmax);
                end
                else
                begin
                    dist_raw = $signed(DIST_W'(r2_root));
                end
            end
            SHAPE_BOX:
                dist_raw = DIST_W'(bmax);
            default:
                dist_raw = $signed(DIST_W'(r2_tag.s1)) - DIST_ONE;
        endcase
        axis_zero = shape_kind_reg[KIND_W-1]
                  & ((size_a_reg == '0) | (size_b_reg == '0) | (size_c_reg == '0));
        if (dist_raw > DIST_MAX)
        begin
            result_next.distance  = DIST_MAX[WORD_W-1:0];
            result_next.saturated = 1'b1;
        end
        else if (dist_raw < DIST_MIN)
        begin
            result_next.distance  = DIST_MIN[WORD_W-1:0];
            result_next.saturated = 1'b1;
        end
        else
        begin
            result_next.distance  = dist_raw[WORD_W-1:0];
            result_next.saturated = axis_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= r2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hw/rtl/psd_check.sv
module psd_check
    import psd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    a_result_follows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done
    ) else $error("transfer accepted without a result after the pipeline latency");

    a_no_stray_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !done
    ) else $error("result strobe without a matching accepted transfer");

    a_quiet_in_reset: assert property (
        @(posedge clk)
        !rst_n |=> !done
    ) else $error("result strobe during reset");

endmodule

bind primitive_signed_distance psd_check u_psd_check (.*);

FILE: sim/tb_primitive_signed_distance.sv
`timescale 1ns / 1ps

module tb_primitive_signed_distance;
    import psd_pkg::*;

    localparam logic [KIND_W-1:0] SHAPE_ELLIPSOID  = 3'd4;
    localparam logic [KIND_W-1:0] SHAPE_SPARE_LOW  = 3'd5;
    localparam logic [KIND_W-1:0] SHAPE_SPARE_HIGH = 3'd7;
    localparam int CYCLE_LIMIT = 400000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    point_t            point;
    logic              done;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic [KIND_W-1:0] cfg_kind;
    longint            cfg_cx, cfg_cy, cfg_cz, cfg_sa, cfg_sb, cfg_sc;

    result_t           expected_distances[$];
    int                error_count;
    int                cycle_count;
    bit                idle_enabled;

    primitive_signed_distance i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .point   (point),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [127:0] square_mag(longint v);
        logic [127:0] m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    function automatic longint floor_root(logic [127:0] n);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int b = 62; b >= 0; b--)
        begin
            c = r | (128'd1 << b);
            if (c * c <= n)
                r = c;
        end
        return longint'(r[63:0]);
    endfunction

    function automatic logic [127:0] axis_ratio(longint d, longint axis);
        logic [127:0] m;
        logic [127:0] q;
        m = (d < 0) ? -d : d;
        if (m == 0)
            return 0;
        if (axis == 0)
            return 128'd1 << WORD_W;
        q = (m << FRAC_W) / axis;
        if (q >= (128'd1 << WORD_W))
            q = 128'd1 << WORD_W;
        return q;
    endfunction

    function automatic result_t shape_distance(point_t p);
        longint       dx, dy, dz, dist_raw, face, side, ex, ey, ez, q;
        logic [127:0] rx, ry, rz;
        logic         flag;
        result_t      r;
        dx = longint'(p.point_x) - cfg_cx;
        dy = longint'(p.point_y) - cfg_cy;
        dz = longint'(p.point_z) - cfg_cz;
        flag = 1'b0;
        case (cfg_kind)
            SHAPE_SPHERE:
                dist_raw = floor_root(square_mag(dx) + square_mag(dy) + square_mag(dz))
                         - cfg_sa;
            SHAPE_TORUS:
            begin
                q = floor_root(square_mag(dx) + square_mag(dy)) - cfg_sa;
                dist_raw = floor_root(square_mag(q) + square_mag(dz)) - cfg_sb;
            end
            SHAPE_CYLINDER:
            begin
                face = 2 * dz + cfg_sa;
                if (face < 0)
                    face = -face;
                face = (face - cfg_sa) >>> 1;
                side = floor_root(square_mag(dx) + square_mag(dy)) - cfg_sb;
                if (face <= 0 || side <= 0)
                    dist_raw = (face > side) ? face : side;
                else
                    dist_raw = floor_root(square_mag(face) + square_mag(side));
            end
            SHAPE_BOX:
            begin
                ex = ((dx < 0 ? -2 * dx : 2 * dx) - cfg_sa) >>> 1;
                ey = ((dy < 0 ? -2 * dy : 2 * dy) - cfg_sb) >>> 1;
                ez = ((dz < 0 ? -2 * dz : 2 * dz) - cfg_sc) >>> 1;
                dist_raw = (ex > ey) ? ex : ey;
                if (ez > dist_raw)
                    dist_raw = ez;
            end
            default:
            begin
                rx = axis_ratio(dx, cfg_sa);
                ry = axis_ratio(dy, cfg_sb);
                rz = axis_ratio(dz, cfg_sc);
                dist_raw = floor_root(rx * rx + ry * ry + rz * rz) - (longint'(1) << FRAC_W);
                if (cfg_sa == 0 || cfg_sb == 0 || cfg_sc == 0)
                    flag = 1'b1;
            end
        endcase
        if (dist_raw > 64'sd2147483647)
        begin
            dist_raw = 64'sd2147483647;
            flag = 1'b1;
        end
        if (dist_raw < -64'sd2147483648)
        begin
            dist_raw = -64'sd2147483648;
            flag = 1'b1;
        end
        r.distance = dist_raw[WORD_W-1:0];
        r.saturated = flag;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_distances.size() == 0)
                report_mismatch($sformatf("unexpected transfer distance=%h", result.distance));
            else
            begin
                result_t exp_r;
                exp_r = expected_distances.pop_front();
                if (result.distance !== exp_r.distance)
                    report_mismatch($sformatf("distance %h expected %h",
                                              result.distance, exp_r.distance));
                if (result.saturated !== exp_r.saturated)
                    report_mismatch($sformatf("saturated %b expected %b",
                                              result.saturated, exp_r.saturated));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
        @(negedge clk);
        start   <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_SHAPE_KIND: cfg_kind = value[KIND_W-1:0];
            REG_CENTRE_X:   cfg_cx = longint'(signed'(value));
            REG_CENTRE_Y:   cfg_cy = longint'(signed'(value));
            REG_CENTRE_Z:   cfg_cz = longint'(signed'(value));
            REG_SIZE_A:     cfg_sa = longint'(value[SIZE_W-1:0]);
            REG_SIZE_B:     cfg_sb = longint'(value[SIZE_W-1:0]);
            REG_SIZE_C:     cfg_sc = longint'(value[SIZE_W-1:0]);
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_shape(logic [2:0] kind, logic [31:0] cx, logic [31:0] cy,
                             logic [31:0] cz, logic [31:0] sa, logic [31:0] sb,
                             logic [31:0] sc);
        wait_drained();
        write_reg(REG_SHAPE_KIND, 32'(kind));
        write_reg(REG_CENTRE_X, cx);
        write_reg(REG_CENTRE_Y, cy);
        write_reg(REG_CENTRE_Z, cz);
        write_reg(REG_SIZE_A, sa);
        write_reg(REG_SIZE_B, sb);
        write_reg(REG_SIZE_C, sc);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (expected_distances.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        point_t p;
        int     gap;
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        @(negedge clk);
        start <= 1'b1;
        point <= p;
        do
            @(posedge clk);
        while (busy);
        expected_distances.push_back(shape_distance(p));
    endtask

    function automatic logic [31:0] near_value(longint c);
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'(c + $signed($urandom_range(0, 32'h0007_ffff)) - 32'h0004_0000);
            2:       return 32'(c + $signed($urandom_range(0, 32'h01ff_ffff)) - 32'h0100_0000);
            default: return 32'(c + $signed($urandom_range(0, 32'h000f)) - 32'h0008);
        endcase
    endfunction

    function automatic logic [31:0] random_size();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'($urandom_range(0, 3));
            default: return 32'($urandom_range(1, 32'h0010_0000));
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0001_0000, 32'h0, 32'h0);
    endtask

    task automatic test_each_shape();
        set_shape(SHAPE_TORUS, 32'h0, 32'h0, 32'h0, 32'h0002_0000, 32'h0000_8000, 32'h0);
        send_point(32'h0002_0000, 32'h0, 32'h0);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        set_shape(SHAPE_CYLINDER, 32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000,
                  32'h0001_0000, 32'h0);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h0003_0000, 32'h0, 32'h0003_0000);
        send_point(32'h0003_0000, 32'h0, 32'hfffd_0000);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        set_shape(SHAPE_BOX, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        set_shape(SHAPE_BOX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'hffff_ffff, 32'h1, 32'h0);
    endtask

    task automatic test_ellipsoid_cases();
        set_shape(SHAPE_ELLIPSOID, 32'h0, 32'h0, 32'h0, 32'h0002_0000, 32'h0001_0000,
                  32'h0000_8000);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h0002_0000, 32'h0, 32'h0);
        // huge ratio from a tiny axis
        set_shape(SHAPE_ELLIPSOID, 32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1);
        send_point(32'h7fff_ffff, 32'h0, 32'h0);
        // zero axis, with and without offset on that axis
        set_shape(SHAPE_ELLIPSOID, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                  32'h0001_0000);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h1, 32'h0, 32'h0);
        // unused shape codes act as ellipsoid
        set_shape(SHAPE_SPARE_HIGH, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
                  32'h0001_0000);
        send_point(32'h0000_8000, 32'h0, 32'h0);
        set_shape(SHAPE_SPARE_LOW, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    endtask

    task automatic test_random_points(int phases, int per_phase);
        for (int ph = 0; ph < phases; ph++)
        begin
            set_shape(ph < 8 ? ph[2:0] : 3'($urandom_range(0, 7)), $urandom, $urandom,
                      $urandom, random_size(), random_size(), random_size());
            idle_enabled = (ph < phases - 2);
            if (ph % 3 == 0)
            begin
                cfg_cx = longint'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'h0080_0000);
                write_reg(REG_CENTRE_X, 32'(cfg_cx));
            end
            for (int n = 0; n < per_phase; n++)
                send_point(near_value(cfg_cx), near_value(cfg_cy), near_value(cfg_cz));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        point = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        cycle_count = 0;
        idle_enabled = 1'b1;
        cfg_kind = SHAPE_SPHERE;
        cfg_cx = 0;
        cfg_cy = 0;
        cfg_cz = 0;
        cfg_sa = 64'h1_0000;
        cfg_sb = 64'h1_0000;
        cfg_sc = 64'h1_0000;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_each_shape();
        test_ellipsoid_cases();
        test_random_points(10, 185);

        wait_drained();
        repeat (LATENCY + 20)
            @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
